[sv/qpr_pkg.sv]
// Shared types and constants for the quaternion point rotation core.
// Field formats, derived datapath widths, item structs and queue status.
// No dependencies.
package qpr_pkg;

    // Item field formats: quaternion is signed Q1.14 and the point is signed Q16.16.
    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int POINT_WIDTH    = 32;

    // Guard bits on the length, and the fraction of the normalized conjugate.
    localparam int NORM_GUARD = 8;
    localparam int B_FRAC     = QUAT_FRAC_BITS + 8;

    // Front half: a = q*v and the sum of squares.
    localparam int PROD_W    = QUAT_WIDTH + POINT_WIDTH;
    localparam int ASUM_W    = PROD_W + 2;
    localparam int A_W       = ASUM_W + 1 - QUAT_FRAC_BITS;
    localparam int SQ_PROD_W = 2 * QUAT_WIDTH;
    localparam int SUMSQ_W   = SQ_PROD_W + 1;

    // Square root of sumsq * 2^(2*NORM_GUARD).
    localparam int RAD_W  = SUMSQ_W + 2 * NORM_GUARD;
    localparam int ROOT_W = (RAD_W + 1) / 2;

    // Division of the conjugate magnitude by the length.
    localparam int MAG_W  = QUAT_WIDTH;
    localparam int NUM_SH = B_FRAC + NORM_GUARD;
    localparam int DIV_Q  = B_FRAC + 1;
    localparam int DVD_W  = MAG_W + NUM_SH + 1;
    localparam int B_W    = B_FRAC + 2;

    // Second Hamilton product and final rounding.
    localparam int RPROD_W = A_W + B_W;
    localparam int RSUM_W  = RPROD_W + 2;
    localparam int RSH_W   = RSUM_W + 1 - B_FRAC;

    // Queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Component order used on all internal lanes.
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0]  quat_x;
        logic signed [QUAT_WIDTH-1:0]  quat_y;
        logic signed [QUAT_WIDTH-1:0]  quat_z;
        logic signed [QUAT_WIDTH-1:0]  quat_w;
        logic signed [POINT_WIDTH-1:0] point_x;
        logic signed [POINT_WIDTH-1:0] point_y;
        logic signed [POINT_WIDTH-1:0] point_z;
    } qpr_in_t;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] out_x;
        logic signed [POINT_WIDTH-1:0] out_y;
        logic signed [POINT_WIDTH-1:0] out_z;
        logic signed [POINT_WIDTH-1:0] out_w;
        logic                          zero_length;
        logic                          overflow;
    } qpr_out_t;

    // What travels alongside the length and division pipelines.
    typedef struct packed {
        logic [3:0][A_W-1:0]   a;       // q*v, signed, fraction of the point
        logic [3:0]            c_neg;   // sign of each conjugate component
        logic [3:0][MAG_W-1:0] c_mag;   // magnitude of each conjugate component
        logic                  zero;    // quaternion is all zero
    } qpr_carry_t;

    typedef struct packed {
        qpr_carry_t           carry;
        logic [SUMSQ_W-1:0]   sumsq;
    } qpr_front_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qpr_qstat_t;

endpackage

[sv/quaternion_point_rotate_core.sv]
// Rotates a Q16.16 point by a Q1.14 quaternion, giving q*v*conj(q)/|q| saturated
// to Q16.16, with flags for a zero quaternion and for saturation. The core takes
// one item per cycle and keeps that rate under any stall pattern that leaves
// the output free. With an empty queue an item passes from acceptance to result
// through 2 front stages after the input register, the queue, 26 stages of the
// bit-serial square root that forms the length, 24 stages of the four-lane
// restoring divider that normalizes the conjugate, and 4 stages for the products,
// sums and saturation. A 4-entry queue between the front and back halves absorbs
// short output stalls.
// Depends on qpr_pkg, qpr_front, qpr_queue and qpr_back.
module quaternion_point_rotate_core
    import qpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     point_valid,
    output logic     point_stall,
    input  qpr_in_t  point_item,
    output logic     result_valid,
    input  logic     result_stall,
    output qpr_out_t result_item
);

    logic       push;
    logic       pop;
    qpr_front_t push_item;
    qpr_front_t head;
    qpr_qstat_t qstat;

    qpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_item  (point_item),
        .qstat       (qstat),
        .push        (push),
        .push_item   (push_item)
    );

    qpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    qpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

[sv/qpr_front.sv]
// Front half of the rotation core: takes input items, forms q*v and |q|^2.
// Three register stages: input, products, sums. Depends on qpr_pkg.
module qpr_front
    import qpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    output logic       point_stall,
    input  qpr_in_t    point_item,
    input  qpr_qstat_t qstat,
    output logic       push,
    output qpr_front_t push_item
);

    localparam logic signed [ASUM_W:0] A_HALF = (ASUM_W + 1)'(2 ** (QUAT_FRAC_BITS - 1));

    logic       fe;
    logic       f1_v_reg;
    logic       f2_v_reg;
    logic       f3_v_reg;
    qpr_in_t    f1_reg;
    logic signed [PROD_W-1:0] prod_reg [0:11];
    logic [SQ_PROD_W-1:0]     sq_reg   [0:3];
    logic [3:0]               c_neg_reg;
    logic [3:0][MAG_W-1:0]    c_mag_reg;
    qpr_front_t front_reg;

    logic signed [PROD_W-1:0]    prod [0:11];
    logic signed [SQ_PROD_W-1:0] sqp  [0:3];
    logic [3:0]                  c_neg;
    logic [3:0][MAG_W-1:0]       c_mag;
    logic signed [ASUM_W-1:0]    asum [0:3];
    logic signed [ASUM_W:0]      arnd [0:3];
    qpr_front_t                  front_next;

    // The whole front moves unless a finished item waits on a full queue
    assign fe          = !f3_v_reg || !qstat.full;
    assign point_stall = !fe;
    assign push        = f3_v_reg && !qstat.full;
    assign push_item   = front_reg;

    // Products of q*v, squares, and the conjugate as sign and magnitude
    always_comb
    begin
        prod[0]  = f1_reg.quat_w * f1_reg.point_x;
        prod[1]  = f1_reg.quat_y * f1_reg.point_z;
        prod[2]  = f1_reg.quat_z * f1_reg.point_y;
        prod[3]  = f1_reg.quat_w * f1_reg.point_y;
        prod[4]  = f1_reg.quat_z * f1_reg.point_x;
        prod[5]  = f1_reg.quat_x * f1_reg.point_z;
        prod[6]  = f1_reg.quat_w * f1_reg.point_z;
        prod[7]  = f1_reg.quat_x * f1_reg.point_y;
        prod[8]  = f1_reg.quat_y * f1_reg.point_x;
        prod[9]  = f1_reg.quat_x * f1_reg.point_x;
        prod[10] = f1_reg.quat_y * f1_reg.point_y;
        prod[11] = f1_reg.quat_z * f1_reg.point_z;
        sqp[0]   = f1_reg.quat_x * f1_reg.quat_x;
        sqp[1]   = f1_reg.quat_y * f1_reg.quat_y;
        sqp[2]   = f1_reg.quat_z * f1_reg.quat_z;
        sqp[3]   = f1_reg.quat_w * f1_reg.quat_w;
        // conj(q) = (-x, -y, -z, w)
        c_neg[LANE_X] = !f1_reg.quat_x[QUAT_WIDTH-1] && (f1_reg.quat_x != '0);
        c_neg[LANE_Y] = !f1_reg.quat_y[QUAT_WIDTH-1] && (f1_reg.quat_y != '0);
        c_neg[LANE_Z] = !f1_reg.quat_z[QUAT_WIDTH-1] && (f1_reg.quat_z != '0);
        c_neg[LANE_W] = f1_reg.quat_w[QUAT_WIDTH-1];
        c_mag[LANE_X] = f1_reg.quat_x[QUAT_WIDTH-1] ? (~f1_reg.quat_x + 1'b1) : f1_reg.quat_x;
        c_mag[LANE_Y] = f1_reg.quat_y[QUAT_WIDTH-1] ? (~f1_reg.quat_y + 1'b1) : f1_reg.quat_y;
        c_mag[LANE_Z] = f1_reg.quat_z[QUAT_WIDTH-1] ? (~f1_reg.quat_z + 1'b1) : f1_reg.quat_z;
        c_mag[LANE_W] = f1_reg.quat_w[QUAT_WIDTH-1] ? (~f1_reg.quat_w + 1'b1) : f1_reg.quat_w;
    end

    // Sums of q*v rounded half up to the point fraction, and |q|^2
    always_comb
    begin
        asum[LANE_X] = ASUM_W'(prod_reg[0]) + ASUM_W'(prod_reg[1]) - ASUM_W'(prod_reg[2]);
        asum[LANE_Y] = ASUM_W'(prod_reg[3]) + ASUM_W'(prod_reg[4]) - ASUM_W'(prod_reg[5]);
        asum[LANE_Z] = ASUM_W'(prod_reg[6]) + ASUM_W'(prod_reg[7]) - ASUM_W'(prod_reg[8]);
        asum[LANE_W] = ASUM_W'(0) - ASUM_W'(prod_reg[9]) - ASUM_W'(prod_reg[10])
                     - ASUM_W'(prod_reg[11]);
        for (int k = 0; k < 4; k++)
        begin
            arnd[k] = (ASUM_W + 1)'(asum[k]) + A_HALF;
            front_next.carry.a[k] = arnd[k][ASUM_W:QUAT_FRAC_BITS];
        end
        front_next.carry.c_neg = c_neg_reg;
        front_next.carry.c_mag = c_mag_reg;
        front_next.sumsq = SUMSQ_W'(sq_reg[0]) + SUMSQ_W'(sq_reg[1])
                         + SUMSQ_W'(sq_reg[2]) + SUMSQ_W'(sq_reg[3]);
        front_next.carry.zero = (front_next.sumsq == '0);
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_v_reg <= point_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            f1_reg    <= point_item;
            prod_reg  <= prod;
            for (int k = 0; k < 4; k++)
            begin
                sq_reg[k] <= sqp[k];
            end
            c_neg_reg <= c_neg;
            c_mag_reg <= c_mag;
            front_reg <= front_next;
        end
    end

endmodule

[sv/qpr_queue.sv]
// Short item queue that decouples the front half from the back half.
// Register array with one read port at the head. Depends on qpr_pkg.
module qpr_queue
    import qpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  qpr_front_t push_item,
    input  logic       pop,
    output qpr_front_t head,
    output qpr_qstat_t qstat
);

    qpr_front_t          mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign qstat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("item pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("item popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

[sv/qpr_back.sv]
// Back half of the rotation core: length by square root, conjugate divided
// by the length, second Hamilton product, rounding and saturation. Depends on qpr_pkg.
module qpr_back
    import qpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qpr_qstat_t qstat,
    input  qpr_front_t head,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output qpr_out_t   result_item
);

    localparam logic signed [RSUM_W:0] B_HALF = (RSUM_W + 1)'(2 ** (B_FRAC - 1));

    logic en;

    // Square root pipeline, one result bit per stage
    logic                  sq_v_reg    [0:ROOT_W];
    logic [2*ROOT_W-1:0]   sq_rad_reg  [0:ROOT_W];
    logic [ROOT_W:0]       sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]     sq_root_reg [0:ROOT_W];
    qpr_carry_t            sq_pay_reg  [0:ROOT_W];

    // Divider pipeline, four lanes sharing the length, one quotient bit per stage
    logic                     dv_v_reg   [0:DIV_Q];
    logic [ROOT_W-1:0]        dv_den_reg [0:DIV_Q];
    logic [3:0][ROOT_W-1:0]   dv_rem_reg [0:DIV_Q];
    logic [3:0][DIV_Q-1:0]    dv_low_reg [0:DIV_Q];
    logic [3:0][DIV_Q-1:0]    dv_quo_reg [0:DIV_Q];
    qpr_carry_t               dv_pay_reg [0:DIV_Q];

    // Normalized conjugate, products, sums, result
    logic                     b_v_reg;
    logic signed [B_W-1:0]    b_reg [0:3];
    logic signed [A_W-1:0]    ba_reg [0:3];
    logic                     b_zero_reg;
    logic                     p_v_reg;
    logic signed [RPROD_W-1:0] pr_reg [0:3][0:3];
    logic                     p_zero_reg;
    logic                     s_v_reg;
    logic signed [RSUM_W-1:0] s_reg [0:3];
    logic                     s_zero_reg;
    logic                     res_v_reg;
    qpr_out_t                 res_reg;

    logic [3:0][DVD_W-1:0]      dvd;
    logic signed [B_W-1:0]      b_next  [0:3];
    logic signed [RPROD_W-1:0]  pr_next [0:3][0:3];
    logic signed [RSUM_W-1:0]   s_next  [0:3];
    logic signed [RSUM_W:0]     rnd     [0:3];
    logic signed [RSH_W-1:0]    sh      [0:3];
    logic [3:0]                 ovf;
    logic [3:0][POINT_WIDTH-1:0] sat;
    qpr_out_t                   res_next;

    // The whole back half moves whenever the result register can take an item
    assign en           = !res_v_reg || !result_stall;
    assign pop          = en && !qstat.empty;
    assign result_valid = res_v_reg;
    assign result_item  = res_reg;

    // Square root entry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= (2 * ROOT_W)'({head.sumsq, (2 * NORM_GUARD)'(0)});
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_pay_reg[0]  <= head.carry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= !qstat.empty;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [ROOT_W+2:0] cand;
        logic [ROOT_W+2:0] trial;
        logic [ROOT_W+2:0] diff;
        logic              take;

        // Bring down two radicand bits, try root*4+1
        always_comb
        begin
            cand  = {sq_rem_reg[k], sq_rad_reg[k][2*ROOT_W-1 -: 2]};
            trial = {1'b0, sq_root_reg[k], 2'b01};
            take  = (cand >= trial);
            diff  = cand - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                sq_rem_reg[k+1]  <= take ? diff[ROOT_W:0] : cand[ROOT_W:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], take};
                sq_pay_reg[k+1]  <= sq_pay_reg[k];
            end
        end
    end

    // Dividend: |c| scaled up, plus half the length for round half away from zero
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            dvd[j] = DVD_W'({sq_pay_reg[ROOT_W].c_mag[j], NUM_SH'(0)})
                   + DVD_W'(sq_root_reg[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_den_reg[0] <= sq_root_reg[ROOT_W];
            dv_pay_reg[0] <= sq_pay_reg[ROOT_W];
            for (int j = 0; j < 4; j++)
            begin
                dv_rem_reg[0][j] <= ROOT_W'(dvd[j] >> DIV_Q);
                dv_low_reg[0][j] <= dvd[j][DIV_Q-1:0];
                dv_quo_reg[0][j] <= '0;
            end
        end
    end

    for (genvar k = 0; k < DIV_Q; k++)
    begin : g_div
        logic [3:0][ROOT_W:0] cand;
        logic [3:0][ROOT_W:0] diff;
        logic [3:0]           take;

        // Restoring step on each lane
        always_comb
        begin
            for (int j = 0; j < 4; j++)
            begin
                cand[j] = {dv_rem_reg[k][j], dv_low_reg[k][j][DIV_Q-1]};
                take[j] = (cand[j] >= {1'b0, dv_den_reg[k]});
                diff[j] = cand[j] - {1'b0, dv_den_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[k+1] <= dv_den_reg[k];
                dv_pay_reg[k+1] <= dv_pay_reg[k];
                for (int j = 0; j < 4; j++)
                begin
                    dv_rem_reg[k+1][j] <= take[j] ? diff[j][ROOT_W-1:0] : cand[j][ROOT_W-1:0];
                    dv_low_reg[k+1][j] <= dv_low_reg[k][j] << 1;
                    dv_quo_reg[k+1][j] <= {dv_quo_reg[k][j][DIV_Q-2:0], take[j]};
                end
            end
        end
    end

    // Signed normalized conjugate; a zero quaternion gives a zero conjugate
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (dv_pay_reg[DIV_Q].zero)
            begin
                b_next[j] = '0;
            end
            else if (dv_pay_reg[DIV_Q].c_neg[j])
            begin
                b_next[j] = B_W'(0) - $signed(B_W'(dv_quo_reg[DIV_Q][j]));
            end
            else
            begin
                b_next[j] = $signed(B_W'(dv_quo_reg[DIV_Q][j]));
            end
        end
    end

    // All sixteen products a_i * b_j
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pr_next[i][j] = ba_reg[i] * b_reg[j];
            end
        end
    end

    // Hamilton product a*b
    always_comb
    begin
        s_next[LANE_X] = RSUM_W'(pr_reg[LANE_X][LANE_W]) + RSUM_W'(pr_reg[LANE_W][LANE_X])
                       + RSUM_W'(pr_reg[LANE_Y][LANE_Z]) - RSUM_W'(pr_reg[LANE_Z][LANE_Y]);
        s_next[LANE_Y] = RSUM_W'(pr_reg[LANE_Y][LANE_W]) + RSUM_W'(pr_reg[LANE_W][LANE_Y])
                       + RSUM_W'(pr_reg[LANE_Z][LANE_X]) - RSUM_W'(pr_reg[LANE_X][LANE_Z]);
        s_next[LANE_Z] = RSUM_W'(pr_reg[LANE_Z][LANE_W]) + RSUM_W'(pr_reg[LANE_W][LANE_Z])
                       + RSUM_W'(pr_reg[LANE_X][LANE_Y]) - RSUM_W'(pr_reg[LANE_Y][LANE_X]);
        s_next[LANE_W] = RSUM_W'(pr_reg[LANE_W][LANE_W]) - RSUM_W'(pr_reg[LANE_X][LANE_X])
                       - RSUM_W'(pr_reg[LANE_Y][LANE_Y]) - RSUM_W'(pr_reg[LANE_Z][LANE_Z]);
    end

    // Round half up to the point fraction, then clamp to the point range
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = (RSUM_W + 1)'(s_reg[k]) + B_HALF;
            sh[k]  = rnd[k][RSUM_W:B_FRAC];
            ovf[k] = !((&sh[k][RSH_W-1:POINT_WIDTH-1]) || !(|sh[k][RSH_W-1:POINT_WIDTH-1]));
            if (!ovf[k])
            begin
                sat[k] = sh[k][POINT_WIDTH-1:0];
            end
            else if (sh[k][RSH_W-1])
            begin
                sat[k] = {1'b1, (POINT_WIDTH - 1)'(0)};
            end
            else
            begin
                sat[k] = {1'b0, {(POINT_WIDTH - 1){1'b1}}};
            end
        end
        res_next.out_x       = sat[LANE_X];
        res_next.out_y       = sat[LANE_Y];
        res_next.out_z       = sat[LANE_Z];
        res_next.out_w       = sat[LANE_W];
        res_next.zero_length = s_zero_reg;
        res_next.overflow    = |ovf;
    end

    // Tail valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg   <= 1'b0;
            p_v_reg   <= 1'b0;
            s_v_reg   <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg   <= dv_v_reg[DIV_Q];
            p_v_reg   <= b_v_reg;
            s_v_reg   <= p_v_reg;
            res_v_reg <= s_v_reg;
        end
    end

    // Tail payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 4; j++)
            begin
                b_reg[j]  <= b_next[j];
                ba_reg[j] <= $signed(dv_pay_reg[DIV_Q].a[j]);
                s_reg[j]  <= s_next[j];
            end
            b_zero_reg <= dv_pay_reg[DIV_Q].zero;
            pr_reg     <= pr_next;
            p_zero_reg <= b_zero_reg;
            s_zero_reg <= p_zero_reg;
            res_reg    <= res_next;
        end
    end

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.zero_length) |->
            (result_item.out_x == '0) && (result_item.out_y == '0) &&
            (result_item.out_z == '0) && (result_item.out_w == '0) && !result_item.overflow)
        else $error("zero quaternion gave a nonzero result");

endmodule
